@@ rtl/core/eth_ipv4_l4_header_parser_defines.svh @@
`ifndef ETH_IPV4_L4_HEADER_PARSER_DEFINES_SVH
`define ETH_IPV4_L4_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define EHP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define EHP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ehp_pkg.sv @@
`default_nettype none

package ehp_pkg;

	localparam logic [10:0] MAX_FRAME_BYTES = 11'd2024;
	localparam logic [10:0] POS_MAX         = 11'd2047;

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_VLAN = 16'h8100;

	// byte positions of the low ethertype bytes
	localparam logic [10:0] OUTER_ETYPE_POS = 11'd13;
	localparam logic [10:0] INNER_ETYPE_POS = 11'd17;

	localparam logic [4:0] IP_START_PLAIN = 5'd14;
	localparam logic [4:0] IP_START_VLAN  = 5'd18;

	localparam logic [3:0] IP_VERSION = 4'd4;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam int FLAG_VLAN = 0;
	localparam int FLAG_TCP  = 1;
	localparam int FLAG_UDP  = 2;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_ETYPE   = 3'd1,
		ST_VLAN_INNER  = 3'd2,
		ST_IP_VERSION  = 3'd3,
		ST_PROTOCOL    = 3'd4,
		ST_TRUNCATED   = 3'd5,
		ST_BAD_LENGTH  = 3'd6
	} status_t;

	// header state after the current beat, plus the l4 start seen before it
	typedef struct packed {
		logic [10:0] count;
		logic [6:0]  l4_start;
		logic [4:0]  ip_start;
		logic [5:0]  ip_hdr_bytes;
		logic [15:0] ip_total_len;
		logic [15:0] l4_field;
		status_t     err;
		logic [2:0]  flags;
	} cap_t;

	typedef struct packed {
		status_t     status;
		logic        vlan_tagged;
		logic        is_udp;
		logic [10:0] payload_offset;
		logic [15:0] payload_size;
		logic [10:0] frame_length;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/core/ehp_frame_if.sv @@
`default_nettype none

interface ehp_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ehp_result_if.sv @@
`default_nettype none

interface ehp_result_if;
	import ehp_pkg::*;

	logic        valid;
	logic        ready;
	status_t     status;
	logic        vlan_tagged;
	logic        is_udp;
	logic [10:0] payload_offset;
	logic [15:0] payload_size;
	logic [10:0] frame_length;

	modport source (output valid, output status, output vlan_tagged, output is_udp,
		output payload_offset, output payload_size, output frame_length, input ready);
	modport sink (input valid, input status, input vlan_tagged, input is_udp,
		input payload_offset, input payload_size, input frame_length, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ehp_capture.sv @@
`default_nettype none
`include "eth_ipv4_l4_header_parser_defines.svh"

module ehp_capture (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_end,
	output ehp_pkg::cap_t    cap
);
	import ehp_pkg::*;

	logic [10:0] pos_q;
	logic [15:0] eth_q;
	logic [4:0]  ip_start_q;
	logic [5:0]  ip_hdr_q;
	logic [15:0] total_q;
	logic [15:0] l4_field_q;
	status_t     err_q;
	logic [2:0]  flags_q;

	logic [15:0] eth_n;
	logic [10:0] ip_pos;
	logic [10:0] l4_pos;

	always_comb begin
		cap.count        = (pos_q != POS_MAX) ? pos_q + 11'd1 : POS_MAX;
		cap.l4_start     = 7'(ip_start_q) + 7'(ip_hdr_q);
		cap.ip_start     = ip_start_q;
		cap.ip_hdr_bytes = ip_hdr_q;
		cap.ip_total_len = total_q;
		cap.l4_field     = l4_field_q;
		cap.err          = err_q;
		cap.flags        = flags_q;
		eth_n            = {eth_q[7:0], data_byte};

		if (pos_q == OUTER_ETYPE_POS) begin
			if (eth_n == ETYPE_VLAN) begin
				cap.flags[FLAG_VLAN] = 1'b1;
				cap.ip_start         = IP_START_VLAN;
			end else if (eth_n != ETYPE_IPV4 && cap.err == ST_OK) begin
				cap.err = ST_BAD_ETYPE;
			end
		end
		if (pos_q == INNER_ETYPE_POS && cap.flags[FLAG_VLAN] && eth_n != ETYPE_IPV4 &&
				cap.err == ST_OK) begin
			cap.err = ST_VLAN_INNER;
		end

		ip_pos = 11'(cap.ip_start);
		l4_pos = 11'(cap.l4_start);
		if (pos_q == ip_pos) begin
			if (data_byte[7:4] != IP_VERSION && cap.err == ST_OK)
				cap.err = ST_IP_VERSION;
			cap.ip_hdr_bytes = {data_byte[3:0], 2'b00};
		end
		if (pos_q == ip_pos + 11'd2)
			cap.ip_total_len = {data_byte, 8'h00};
		if (pos_q == ip_pos + 11'd3)
			cap.ip_total_len = {cap.ip_total_len[15:8], data_byte};
		if (pos_q == ip_pos + 11'd9) begin
			if (data_byte == PROTO_TCP)
				cap.flags[FLAG_TCP] = 1'b1;
			else if (data_byte == PROTO_UDP)
				cap.flags[FLAG_UDP] = 1'b1;
			else if (cap.err == ST_OK)
				cap.err = ST_PROTOCOL;
		end
		// l4 header fields: udp length, or tcp data offset at byte 12
		if (pos_q > ip_pos) begin
			if (pos_q == l4_pos + 11'd4)
				cap.l4_field = {data_byte, 8'h00};
			if (pos_q == l4_pos + 11'd5)
				cap.l4_field = {cap.l4_field[15:8], data_byte};
			if (pos_q == l4_pos + 11'd12 && cap.flags[FLAG_TCP])
				cap.l4_field = {10'd0, data_byte[7:4], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			eth_q      <= '0;
			ip_start_q <= IP_START_PLAIN;
			ip_hdr_q   <= '0;
			total_q    <= '0;
			l4_field_q <= '0;
			err_q      <= ST_OK;
			flags_q    <= '0;
		end else if (adv) begin
			if (frame_end) begin
				pos_q      <= '0;
				eth_q      <= '0;
				ip_start_q <= IP_START_PLAIN;
				ip_hdr_q   <= '0;
				total_q    <= '0;
				l4_field_q <= '0;
				err_q      <= ST_OK;
				flags_q    <= '0;
			end else begin
				pos_q      <= cap.count;
				eth_q      <= eth_n;
				ip_start_q <= cap.ip_start;
				ip_hdr_q   <= cap.ip_hdr_bytes;
				total_q    <= cap.ip_total_len;
				l4_field_q <= cap.l4_field;
				err_q      <= cap.err;
				flags_q    <= cap.flags;
			end
		end
	end

	`EHP_ASSERT_NEXT(a_frame_restart, adv && frame_end,
		pos_q == 11'd0 && err_q == ST_OK && flags_q == 3'd0, "state not cleared after frame")
	`EHP_ASSERT_NOW(a_single_l4_proto, 1'b1, !(flags_q[FLAG_TCP] && flags_q[FLAG_UDP]),
		"both tcp and udp captured")
	`EHP_ASSERT_NOW(a_ip_start_vlan, 1'b1,
		flags_q[FLAG_VLAN] == (ip_start_q == IP_START_VLAN), "ip start disagrees with vlan flag")

endmodule

`default_nettype wire

@@ rtl/core/ehp_result.sv @@
`default_nettype none

module ehp_result (
	input  wire ehp_pkg::cap_t cap,
	output ehp_pkg::res_t      res
);
	import ehp_pkg::*;

	logic        tcp;
	logic        udp;
	logic [10:0] ip_min;
	logic [10:0] tcp_min;
	logic [10:0] udp_min;
	logic [17:0] tcp_size;
	logic [17:0] udp_size;
	logic [17:0] size;
	logic [10:0] offset;
	status_t     status;

	always_comb begin
		tcp      = cap.flags[FLAG_TCP];
		udp      = cap.flags[FLAG_UDP];
		ip_min   = 11'(cap.ip_start) + 11'd10;
		tcp_min  = 11'(cap.l4_start) + 11'd13;
		udp_min  = 11'(cap.l4_start) + 11'd6;
		tcp_size = {2'b00, cap.ip_total_len} - 18'(cap.ip_hdr_bytes)
			- {2'b00, cap.l4_field};
		udp_size = {2'b00, cap.l4_field} - 18'd8;
		size     = '0;
		offset   = '0;
		status   = ST_OK;

		if (cap.count >= MAX_FRAME_BYTES) begin
			status = ST_BAD_LENGTH;
		end else if (cap.err != ST_OK) begin
			status = cap.err;
		end else if (cap.count < ip_min || (tcp && cap.count < tcp_min) ||
				(udp && cap.count < udp_min)) begin
			status = ST_TRUNCATED;
		end else if (tcp) begin
			offset = 11'(cap.l4_start) + cap.l4_field[10:0];
			size   = tcp_size;
		end else begin
			offset = 11'(cap.l4_start) + 11'd8;
			size   = udp_size;
		end
		// sign bit of the 18-bit difference
		if (status == ST_OK && size[17])
			status = ST_BAD_LENGTH;

		res.status         = status;
		res.vlan_tagged    = cap.flags[FLAG_VLAN];
		res.is_udp         = udp;
		res.payload_offset = (status == ST_OK) ? offset : 11'd0;
		res.payload_size   = (status == ST_OK) ? size[15:0] : 16'd0;
		res.frame_length   = cap.count;
	end

endmodule

`default_nettype wire

@@ rtl/core/eth_ipv4_l4_header_parser.sv @@
// channel | dir | per beat                              | handshake
// frame   | in  | data_byte[7:0], frame_end             | valid/ready
// result  | out | status, vlan_tagged, is_udp,          | valid/ready
//         |     | payload_offset, payload_size, length  |
// one frame byte per cycle unless a held result stalls a last byte;
// the byte register feeds header capture, whose state updates per byte
// a result appears on the cycle after the last byte leaves the byte register
// arst_n clears all control and header state; no clearing pass
// a held result stalls only a last byte; other bytes keep flowing
`default_nettype none
`include "eth_ipv4_l4_header_parser_defines.svh"

module eth_ipv4_l4_header_parser (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ehp_frame_if.sink     frame,
	ehp_result_if.source  result
);
	import ehp_pkg::*;

	logic       byte_valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       res_valid_q;
	res_t       res_q;
	logic       adv;
	cap_t       cap;
	res_t       res;

	// a last byte needs a free result slot
	assign adv         = byte_valid_s1 && (!last_s1 || !res_valid_q || result.ready);
	assign frame.ready = !byte_valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (frame.valid && frame.ready) begin
			byte_valid_s1 <= 1'b1;
		end else if (adv) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			byte_s1 <= frame.data_byte;
			last_s1 <= frame.frame_end;
		end
	end

	ehp_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.data_byte (byte_s1),
		.frame_end (last_s1),
		.cap       (cap)
	);

	ehp_result u_result (
		.cap (cap),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1)
			res_q <= res;
	end

	assign result.valid          = res_valid_q;
	assign result.status         = res_q.status;
	assign result.vlan_tagged    = res_q.vlan_tagged;
	assign result.is_udp         = res_q.is_udp;
	assign result.payload_offset = res_q.payload_offset;
	assign result.payload_size   = res_q.payload_size;
	assign result.frame_length   = res_q.frame_length;

	`EHP_ASSERT_NOW(a_result_from_last, $rose(res_valid_q), $past(adv && last_s1),
		"result without a last byte")
	`EHP_ASSERT_NOW(a_error_fields_zero, res_valid_q && res_q.status != ST_OK,
		res_q.payload_offset == 11'd0 && res_q.payload_size == 16'd0,
		"error result carries payload fields")
	`EHP_ASSERT_NOW(a_ok_short_frame, res_valid_q && res_q.status == ST_OK,
		res_q.frame_length < MAX_FRAME_BYTES, "long frame reported ok")

endmodule

`default_nettype wire
